/* sv/unbounded_knapsack_engine_macros.svh */
// assertion macros for the unbounded knapsack engine
`ifndef UNBOUNDED_KNAPSACK_ENGINE_MACROS_SVH
`define UNBOUNDED_KNAPSACK_ENGINE_MACROS_SVH

// same-cycle implication, checked outside reset
`define UKE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("knapsack engine check failed");

// next-cycle implication, checked outside reset
`define UKE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("knapsack engine check failed");

`endif

/* sv/uke_pkg.sv */
// shared constants and types for the unbounded knapsack engine
`timescale 1ns / 1ps
`default_nettype none

package uke_pkg;

    // table geometry and value width
    localparam int TABLE_DEPTH     = 1024;
    localparam int ADDR_BITS       = $clog2(TABLE_DEPTH);
    localparam int VALUE_BITS      = 16;

    // fixed field widths
    localparam int WEIGHT_BITS     = 10;
    localparam int ITEM_VALUE_BITS = 16;
    localparam int CAP_BITS        = 10;
    localparam int DATA_BITS       = 32;

    // item value mask
    localparam logic [ITEM_VALUE_BITS-1:0] VALUE_MASK =
        ITEM_VALUE_BITS'((64'd1 << VALUE_BITS) - 64'd1);

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [DATA_BITS-1:0] t_data;

    localparam t_addr ADDR_MAX = t_addr'(TABLE_DEPTH - 1);

    // table access request from the sequencer
    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_data wdata;
        t_addr raddr_a;
        t_addr raddr_b;
    } t_tbl_req;

    // registered table read data
    typedef struct packed {
        t_data q_a;
        t_data q_b;
    } t_tbl_rsp;

endpackage

`default_nettype wire

/* sv/unbounded_knapsack_engine.sv */
// unbounded knapsack engine top level: sequencer, table and relax unit
//
//   channel   signals                                     direction
//   config    i_cfg_we, i_cfg_wdata                        in, write only
//   item      start, busy, i_item_weight/value, i_last_item in, start/busy
//   result    o_result_valid, o_best_value, o_saturated    out, one-cycle strobe
//
// An item of weight w (1 to TABLE_DEPTH-1) holds busy through a pass over
// entries w to TABLE_DEPTH-1: one table entry per cycle through the relax unit,
// then a drain state. A weight of zero is taken without a pass.
// A last item then runs the read and result states, then a clearing pass
// over all TABLE_DEPTH entries (1024) that zeroes the table; the same pass runs
// after reset. The result strobe cannot be stalled; config writes are taken anytime.
`timescale 1ns / 1ps
`default_nettype none

module unbounded_knapsack_engine
    import uke_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [CAP_BITS-1:0]        i_cfg_wdata,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [WEIGHT_BITS-1:0]     i_item_weight,
    input  wire logic [ITEM_VALUE_BITS-1:0] i_item_value,
    input  wire logic                       i_last_item,
    output logic                            o_result_valid,
    output logic [DATA_BITS-1:0]            o_best_value,
    output logic                            o_saturated
);

`include "unbounded_knapsack_engine_macros.svh"

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PASS,
        S_DRAIN,
        S_READ,
        S_RESULT
    } t_state;

    t_state                       r_state,    n_state;
    t_addr                        r_idx,      n_idx;
    t_addr                        r_w,        n_w;
    logic [ITEM_VALUE_BITS-1:0]   r_v,        n_v;
    logic                         r_last,     n_last;
    logic                         r_p_valid,  n_p_valid;
    t_addr                        r_p_idx,    n_p_idx;
    logic                         r_ovf,      n_ovf;
    logic [CAP_BITS-1:0]          r_capacity, n_capacity;
    logic                         r_valid,    n_valid;
    t_data                        r_best,     n_best;
    logic                         r_sat,      n_sat;

    t_tbl_req tbl_req;
    t_tbl_rsp tbl_rsp;
    t_data    relax_best;
    logic     relax_ovf;
    logic     weight_ok;
    t_addr    cap_addr;

    uke_table u_table (
        .i_clk (i_clk),
        .i_req (tbl_req),
        .o_rsp (tbl_rsp)
    );

    uke_relax u_relax (
        .i_value (r_v),
        .i_cur   (tbl_rsp.q_a),
        .i_base  (tbl_rsp.q_b),
        .o_best  (relax_best),
        .o_ovf   (relax_ovf)
    );

    // item qualifies for a pass and capacity clamp
    assign weight_ok = (i_item_weight != '0) &&
                       (32'(i_item_weight) < 32'(TABLE_DEPTH));
    assign cap_addr  = (32'(r_capacity) > 32'(TABLE_DEPTH - 1)) ?
                       ADDR_MAX : t_addr'(r_capacity);

    // sequencer next state and table requests
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_w        = r_w;
        n_v        = r_v;
        n_last     = r_last;
        n_p_valid  = 1'b0;
        n_p_idx    = r_idx;
        n_ovf      = r_ovf | (r_p_valid & relax_ovf);
        n_capacity = i_cfg_we ? i_cfg_wdata : r_capacity;
        n_valid    = 1'b0;
        n_best     = r_best;
        n_sat      = r_sat;

        tbl_req.we      = r_p_valid;
        tbl_req.waddr   = r_p_idx;
        tbl_req.wdata   = relax_best;
        tbl_req.raddr_a = r_idx;
        tbl_req.raddr_b = r_idx - r_w;

        case (r_state)
            S_CLEAR: begin
                tbl_req.we    = 1'b1;
                tbl_req.waddr = r_idx;
                tbl_req.wdata = '0;
                n_idx         = r_idx + t_addr'(1);
                if (r_idx == ADDR_MAX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_w    = t_addr'(i_item_weight);
                    n_v    = i_item_value & VALUE_MASK;
                    n_last = i_last_item;
                    if (weight_ok) begin
                        n_idx   = t_addr'(i_item_weight);
                        n_state = S_PASS;
                    end else if (i_last_item) begin
                        n_state = S_READ;
                    end
                end
            end
            S_PASS: begin
                n_p_valid = 1'b1;
                n_p_idx   = r_idx;
                n_idx     = r_idx + t_addr'(1);
                if (r_idx == ADDR_MAX) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = r_last ? S_READ : S_IDLE;
            end
            S_READ: begin
                tbl_req.raddr_a = cap_addr;
                n_state         = S_RESULT;
            end
            S_RESULT: begin
                n_valid = 1'b1;
                n_best  = tbl_rsp.q_a;
                n_sat   = r_ovf;
                n_ovf   = 1'b0;
                n_idx   = '0;
                n_state = S_CLEAR;
            end
            default: begin
                n_state = S_CLEAR;
                n_idx   = '0;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_idx      <= '0;
            r_p_valid  <= 1'b0;
            r_ovf      <= 1'b0;
            r_capacity <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_p_valid  <= n_p_valid;
            r_ovf      <= n_ovf;
            r_capacity <= n_capacity;
            r_valid    <= n_valid;
        end
        r_w     <= n_w;
        r_v     <= n_v;
        r_last  <= n_last;
        r_p_idx <= n_p_idx;
        r_best  <= n_best;
        r_sat   <= n_sat;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_valid;
    assign o_best_value   = r_best;
    assign o_saturated    = r_sat;

    // a result is always followed by the clearing pass
    `UKE_ASSERT_NEXT(a_result_then_busy, o_result_valid, busy && !o_result_valid)
    // no table write while waiting for an item
    `UKE_ASSERT_NOW(a_idle_no_write, r_state == S_IDLE, !tbl_req.we)
    // an accepted item never lands in the middle of a pass
    `UKE_ASSERT_NOW(a_pass_not_idle, r_p_valid, busy)

endmodule

`default_nettype wire

/* sv/uke_table.sv */
// best-value table memory with two read ports and write forwarding
`timescale 1ns / 1ps
`default_nettype none

module uke_table
    import uke_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_tbl_req i_req,
    output t_tbl_rsp      o_rsp
);

    t_data r_mem [TABLE_DEPTH];
    t_data r_qa;
    t_data r_qb;
    t_data r_wd;
    logic  r_fwd_a;
    logic  r_fwd_b;

    // one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_qa    <= r_mem[i_req.raddr_a];
        r_qb    <= r_mem[i_req.raddr_b];
        r_fwd_a <= i_req.we && (i_req.waddr == i_req.raddr_a);
        r_fwd_b <= i_req.we && (i_req.waddr == i_req.raddr_b);
        r_wd    <= i_req.wdata;
    end

    // a read that meets a write to the same entry returns the new data
    assign o_rsp.q_a = r_fwd_a ? r_wd : r_qa;
    assign o_rsp.q_b = r_fwd_b ? r_wd : r_qb;

endmodule

`default_nettype wire

/* sv/uke_relax.sv */
// shared relax unit: saturating add of item value and compare against entry
`timescale 1ns / 1ps
`default_nettype none

module uke_relax
    import uke_pkg::*;
(
    input  wire logic [ITEM_VALUE_BITS-1:0] i_value,
    input  wire t_data                      i_cur,
    input  wire t_data                      i_base,
    output t_data                           o_best,
    output logic                            o_ovf
);

    logic [DATA_BITS:0] sum;
    t_data              cand;

    // candidate with saturation at all ones
    always_comb begin
        sum    = {1'b0, i_base} + (DATA_BITS + 1)'(i_value);
        o_ovf  = sum[DATA_BITS];
        cand   = o_ovf ? '1 : sum[DATA_BITS-1:0];
        o_best = (cand > i_cur) ? cand : i_cur;
    end

endmodule

`default_nettype wire

/* dv/unbounded_knapsack_engine_tb.sv */
// self-checking testbench for the unbounded knapsack engine: directed table, then random problems
`timescale 1ns / 1ps

module unbounded_knapsack_engine_tb
    import uke_pkg::*;
();

    localparam int RANDOM_ITEMS = 580;
    localparam int PHASES       = 9;
    localparam int CALM_ITEMS   = 80;
    localparam int SETTLE_GAP   = TABLE_DEPTH + 64;
    localparam int CYCLE_LIMIT  = 6_000_000;
    localparam int REPORT_MAX   = 10;

    // one expected answer of a problem
    typedef struct packed {
        logic [DATA_BITS-1:0] best;
        logic                 sat;
    } t_total;

    // one directed stimulus row
    typedef struct packed {
        logic                       set_cap;
        logic [CAP_BITS-1:0]        cap;
        logic [WEIGHT_BITS-1:0]     weight;
        logic [ITEM_VALUE_BITS-1:0] value;
        logic                       last;
        logic                       typed;
        logic [DATA_BITS-1:0]       best;
    } t_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CAP_BITS-1:0]        i_cfg_wdata;
    logic                       start;
    logic                       busy;
    logic [WEIGHT_BITS-1:0]     i_item_weight;
    logic [ITEM_VALUE_BITS-1:0] i_item_value;
    logic                       i_last_item;
    logic                       o_result_valid;
    logic [DATA_BITS-1:0]       o_best_value;
    logic                       o_saturated;

    // hand-typed answer riding along with the item being offered
    logic                       pin_use;
    logic [DATA_BITS-1:0]       pin_best;

    // shadow of the engine state
    logic [DATA_BITS-1:0] best_by_cap [TABLE_DEPTH];
    logic                 ovf_seen;
    logic [CAP_BITS-1:0]  cap_shadow;

    t_total expected_totals[$];
    t_row   directed_rows[$];
    int     mismatches  = 0;
    int     cycle_count = 0;

    unbounded_knapsack_engine dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .start          (start),
        .busy           (busy),
        .i_item_weight  (i_item_weight),
        .i_item_value   (i_item_value),
        .i_last_item    (i_last_item),
        .o_result_valid (o_result_valid),
        .o_best_value   (o_best_value),
        .o_saturated    (o_saturated)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL unbounded_knapsack_engine");
            $finish;
        end
    end

    // empty the shadow table for a new problem
    task automatic clear_problem_shadow;
        for (int c = 0; c < TABLE_DEPTH; c++)
            best_by_cap[c] = '0;
        ovf_seen = 1'b0;
    endtask

    // forward pass of one item over the whole table, saturating sums
    task automatic relax_item(input logic [WEIGHT_BITS-1:0] w,
                              input logic [ITEM_VALUE_BITS-1:0] v);
        logic [DATA_BITS:0] cand;
        int                 wi;
        wi = int'(w);
        for (int c = wi; c < TABLE_DEPTH; c++) begin
            cand = {1'b0, best_by_cap[c - wi]} + (DATA_BITS+1)'(v);
            if (cand[DATA_BITS]) begin
                cand     = {1'b0, {DATA_BITS{1'b1}}};
                ovf_seen = 1'b1;
            end
            if (cand[DATA_BITS-1:0] > best_by_cap[c])
                best_by_cap[c] = cand[DATA_BITS-1:0];
        end
    endtask

    task automatic report_mismatch(input string what, input logic [DATA_BITS-1:0] want,
                                   input logic [DATA_BITS-1:0] got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    endtask

    // result check, config shadow and item prediction at each edge
    always @(posedge i_clk) begin
        t_total                     want;
        logic [CAP_BITS-1:0]        cap_read;
        logic [ITEM_VALUE_BITS-1:0] v_masked;
        if (!i_rst_n) begin
            clear_problem_shadow();
            cap_shadow = '0;
        end else begin
            // result transfer
            if (o_result_valid) begin
                if (expected_totals.size() == 0) begin
                    report_mismatch("unexpected result best_value", '0, o_best_value);
                end else begin
                    want = expected_totals.pop_front();
                    if (o_best_value !== want.best)
                        report_mismatch("best_value", want.best, o_best_value);
                    if (o_saturated !== want.sat)
                        report_mismatch("saturated", DATA_BITS'(want.sat),
                                        DATA_BITS'(o_saturated));
                end
            end
            // capacity write
            if (i_cfg_we)
                cap_shadow = i_cfg_wdata;
            // item transfer
            if (start && !busy) begin
                v_masked = i_item_value & VALUE_MASK;
                if (i_item_weight != '0)
                    relax_item(i_item_weight, v_masked);
                if (i_last_item) begin
                    cap_read = (cap_shadow > ADDR_MAX) ? ADDR_MAX : cap_shadow;
                    want.best = best_by_cap[cap_read];
                    want.sat  = ovf_seen;
                    if (pin_use) begin
                        want.best = pin_best;
                        want.sat  = 1'b0;
                    end
                    expected_totals.push_back(want);
                    clear_problem_shadow();
                end
            end
        end
    end

    // offer one item and hold it until the engine takes it
    task automatic send_item(input logic [WEIGHT_BITS-1:0] w,
                             input logic [ITEM_VALUE_BITS-1:0] v,
                             input logic last, input logic typed,
                             input logic [DATA_BITS-1:0] best);
        bit taken;
        taken = 1'b0;
        @(negedge i_clk);
        start         <= 1'b1;
        i_item_weight <= w;
        i_item_value  <= v;
        i_last_item   <= last;
        pin_use       <= typed;
        pin_best      <= best;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
        end
    endtask

    task automatic drop_start;
        if (start) begin
            @(negedge i_clk);
            start   <= 1'b0;
            pin_use <= 1'b0;
        end
    endtask

    // random sender idle burst, sometimes placed at the start of an idle phase
    task automatic maybe_idle(input bit allow);
        int n;
        if (allow && $urandom_range(0, 99) < 35) begin
            n = $urandom_range(1, 13);
            drop_start();
            if ($urandom_range(0, 1) == 1)
                while (busy) @(posedge i_clk);
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // wait until all answers are in and the clearing pass is surely over
    task automatic settle_idle;
        drop_start();
        while (expected_totals.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (SETTLE_GAP) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
        settle_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic t_row row(input logic set_cap, input logic [CAP_BITS-1:0] cap,
                                 input logic [WEIGHT_BITS-1:0] w,
                                 input logic [ITEM_VALUE_BITS-1:0] v, input logic last,
                                 input logic typed, input logic [DATA_BITS-1:0] best);
        t_row r;
        r.set_cap = set_cap;
        r.cap     = cap;
        r.weight  = w;
        r.value   = v;
        r.last    = last;
        r.typed   = typed;
        r.best    = best;
        return r;
    endfunction

    // stimulus
    initial begin
        t_row                       r;
        int                         sent;
        int                         goal;
        int                         len;
        int                         sel;
        bit                         broken;
        logic [CAP_BITS-1:0]        cap_now;
        logic [WEIGHT_BITS-1:0]     w;
        logic [ITEM_VALUE_BITS-1:0] v;
        logic                       last;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        start         = 1'b0;
        i_item_weight = '0;
        i_item_value  = '0;
        i_last_item   = 1'b0;
        pin_use       = 1'b0;
        pin_best      = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty problem after reset, then capacity zero
        directed_rows.push_back(row(1, 0,      0,       0,       1, 1, 0));
        directed_rows.push_back(row(0, 0,      1,       16'hFFFF, 1, 1, 0));
        // full capacity with the densest and the heaviest item
        directed_rows.push_back(row(1, 1023,   1,       16'hFFFF, 1, 1, 32'd67042305));
        directed_rows.push_back(row(0, 0,      1023,    16'hFFFF, 1, 1, 32'd65535));
        // zero-value item, then a weight-zero last item
        directed_rows.push_back(row(0, 0,      1023,    0,       0, 0, 0));
        directed_rows.push_back(row(0, 0,      0,       16'hFFFF, 1, 1, 0));
        // small mixed problem with a skipped item inside
        directed_rows.push_back(row(0, 0,      3,       7,       0, 0, 0));
        directed_rows.push_back(row(0, 0,      5,       13,      0, 0, 0));
        directed_rows.push_back(row(0, 0,      0,       9,       0, 0, 0));
        directed_rows.push_back(row(0, 0,      2,       4,       1, 0, 0));
        // alternating bit patterns
        directed_rows.push_back(row(0, 0,      10'h2AA, 16'hAAAA, 0, 0, 0));
        directed_rows.push_back(row(0, 0,      10'h155, 16'h5555, 1, 0, 0));
        // item heavier than the capacity, then one that just fits
        directed_rows.push_back(row(1, 10,     11,      100,     1, 1, 0));
        directed_rows.push_back(row(0, 0,      10,      100,     1, 1, 100));
        directed_rows.push_back(row(0, 0,      1,       1,       0, 0, 0));
        directed_rows.push_back(row(0, 0,      4,       5,       1, 0, 0));
        // two copies beat one larger item
        directed_rows.push_back(row(1, 512,    512,     16'hFFFF, 0, 0, 0));
        directed_rows.push_back(row(0, 0,      256,     40000,   1, 1, 80000));
        // capacity moved between items of one problem
        directed_rows.push_back(row(1, 100,    7,       9,       0, 0, 0));
        directed_rows.push_back(row(1, 1023,   1000,    1,       1, 0, 0));
        directed_rows.push_back(row(1, 1,      1,       16'hFFFF, 0, 0, 0));
        directed_rows.push_back(row(0, 0,      1023,    1,       1, 1, 65535));

        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            if (r.set_cap)
                write_capacity(r.cap);
            send_item(r.weight, r.value, r.last, r.typed, r.best);
            maybe_idle(1'b1);
        end

        // random problems over a series of capacities
        sent = 0;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       cap_now = 1023;
                1:       cap_now = 0;
                2:       cap_now = 1;
                3:       cap_now = CAP_BITS'($urandom_range(2, 63));
                4:       cap_now = CAP_BITS'($urandom_range(0, 1023));
                5:       cap_now = 1022;
                6:       cap_now = CAP_BITS'($urandom_range(512, 1023));
                7:       cap_now = CAP_BITS'($urandom_range(64, 511));
                default: cap_now = 1023;
            endcase
            write_capacity(cap_now);
            goal = (phase == PHASES - 1) ? RANDOM_ITEMS : sent + RANDOM_ITEMS / PHASES;
            while (sent < goal) begin
                len    = $urandom_range(1, 6);
                broken = ($urandom_range(0, 9) == 0);
                for (int k = 0; k < len; k++) begin
                    sel = $urandom_range(0, 99);
                    if (sel < 10)
                        w = 0;
                    else if (sel < 25)
                        w = WEIGHT_BITS'($urandom_range(1, 8));
                    else if (sel < 35)
                        w = WEIGHT_BITS'($urandom_range(1000, 1023));
                    else
                        w = WEIGHT_BITS'($urandom_range(1, 1023));
                    sel = $urandom_range(0, 99);
                    if (sel < 5)
                        v = 0;
                    else if (sel < 10)
                        v = 16'hFFFF;
                    else
                        v = ITEM_VALUE_BITS'($urandom_range(0, 65535));
                    // broken problems close or stay open at random points
                    last = broken ? 1'($urandom_range(0, 1)) : (k == len - 1);
                    send_item(w, v, last, 1'b0, '0);
                    sent++;
                    maybe_idle(sent < RANDOM_ITEMS - CALM_ITEMS);
                end
            end
        end

        settle_idle();
        mismatches += expected_totals.size();
        if (mismatches == 0)
            $display("PASS unbounded_knapsack_engine");
        else
            $display("FAIL unbounded_knapsack_engine");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/uke_pkg.sv
sv/uke_table.sv
sv/uke_relax.sv
sv/unbounded_knapsack_engine.sv
dv/unbounded_knapsack_engine_tb.sv
